@@ sv/brm_pkg.sv @@
// Shared constants and types for the radix-2 Booth multiplier.
package brm_pkg;

  localparam int OPERAND_W     = 32;
  localparam int PRODUCT_W     = 64;
  localparam int CFG_W         = 6;
  localparam int MAX_WIDTH_DEF = 32;

  // Per-round control broadcast to every bit cell.
  typedef struct packed {
    logic load;    // capture new operands, clear accumulator
    logic step;    // run one add/subtract and shift round
    logic add_en;  // Booth pair asks for an add or a subtract
    logic sub;     // subtract the multiplicand
  } brm_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } brm_state_e;

endpackage

@@ sv/brm_cell.sv @@
// One bit slice of the Booth datapath: accumulator, multiplier and multiplicand bits.
module brm_cell import brm_pkg::*; (
  input  logic      clk_i,
  input  brm_ctrl_t ctrl_i,
  input  logic      active_i,   // slice lies below the operand width
  input  logic      top_i,      // slice is the most significant active one
  input  logic      mcand_i,
  input  logic      mplier_i,
  input  logic      carry_i,
  output logic      carry_o,
  output logic      sum_o,
  input  logic      sum_up_i,   // neighbor's sum bit, shifts down into this slice
  output logic      q_o,
  input  logic      q_up_i,
  input  logic      msb_i,      // sign bit kept by the arithmetic shift
  input  logic      sum0_i      // lowest sum bit, enters the multiplier at the top
);

  logic a_q, a_d;
  logic q_q, q_d;
  logic m_q, m_d;
  logic b;

  assign b       = ctrl_i.add_en & (m_q ^ ctrl_i.sub);
  assign sum_o   = a_q ^ b ^ carry_i;
  assign carry_o = (a_q & b) | (a_q & carry_i) | (b & carry_i);
  assign q_o     = q_q;

  always_comb begin
    a_d = a_q;
    q_d = q_q;
    m_d = m_q;
    if (ctrl_i.load) begin
      a_d = 1'b0;
      q_d = mplier_i & active_i;
      m_d = mcand_i & active_i;
    end else if (ctrl_i.step) begin
      a_d = active_i & (top_i ? msb_i : sum_up_i);
      q_d = active_i & (top_i ? sum0_i : q_up_i);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    q_q <= q_d;
    m_q <= m_d;
  end

endmodule

@@ sv/brm_array.sv @@
// Row of bit cells with the ripple carry and shift links between neighbors.
module brm_array import brm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic                 clk_i,
  input  brm_ctrl_t            ctrl_i,
  input  logic [WW-1:0]        width_i,
  input  logic [MAX_WIDTH-1:0] mcand_i,
  input  logic [MAX_WIDTH-1:0] mplier_i,
  output logic [MAX_WIDTH-1:0] a_o,
  output logic [MAX_WIDTH-1:0] q_o
);

  logic [MAX_WIDTH:0]   carry;
  logic [MAX_WIDTH-1:0] sum_w;
  logic [MAX_WIDTH-1:0] q_w;
  logic [MAX_WIDTH-1:0] active;
  logic [MAX_WIDTH-1:0] top;
  logic                 msb;

  assign carry[0] = ctrl_i.add_en & ctrl_i.sub;
  assign msb      = |(top & sum_w);
  assign q_o      = q_w;

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    logic sum_up;
    logic q_up;

    assign active[i] = WW'(i) < width_i;
    assign top[i]    = WW'(i + 1) == width_i;

    if (i == MAX_WIDTH - 1) begin : g_last
      assign sum_up = 1'b0;
      assign q_up   = 1'b0;
    end else begin : g_mid
      assign sum_up = sum_w[i+1];
      assign q_up   = q_w[i+1];
    end

    brm_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_i),
      .active_i (active[i]),
      .top_i    (top[i]),
      .mcand_i  (mcand_i[i]),
      .mplier_i (mplier_i[i]),
      .carry_i  (carry[i]),
      .carry_o  (carry[i+1]),
      .sum_o    (sum_w[i]),
      .sum_up_i (sum_up),
      .q_o      (q_w[i]),
      .q_up_i   (q_up),
      .msb_i    (msb),
      .sum0_i   (sum_w[0])
    );

    // with no add pending the sum bit is the stored accumulator bit
    assign a_o[i] = sum_w[i];
  end

endmodule

@@ sv/booth_radix2_multiplier_core.sv @@
// Signed radix-2 Booth multiplier, top level.
//
// Input stream: s_axis tdata carries multiplicand (bits 31:0) and multiplier
// (bits 63:32); only the low W operand bits are used, W being the operand
// width register clamped to 1..MAX_WIDTH. Output stream: m_axis tdata is the
// raw 2W-bit product, accumulator half above the multiplier half, zeros above.
// The config channel writes the 6-bit operand width; write it only while idle.
//
// One word is worked on at a time. After a word is taken, a row of MAX_WIDTH
// bit cells runs W add/subtract-and-shift rounds, one per cycle, and the
// product is then moved into the output register once that register is free.
// A new word is taken in that same transfer cycle, so sustained throughput is
// set by the single shared adder row doing one Booth round per cycle. The
// output register holds a finished word while the receiver stalls; the next
// product is computed meanwhile and waits in the cell row until the register
// frees up. Reset empties the output, returns to idle and sets the width to
// MAX_WIDTH.
module booth_radix2_multiplier_core import brm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*OPERAND_W-1:0] s_axis_tdata,  // multiplicand[31:0], multiplier[63:32]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PRODUCT_W-1:0]  m_axis_tdata,   // product[63:0]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i      // operand_width[5:0]
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  brm_state_e           state_q, state_d;
  logic [WW-1:0]        width_q, width_d;
  logic [WW-1:0]        cnt_q, cnt_d;
  logic                 q1_q, q1_d;
  logic                 out_valid_q, out_valid_d;
  logic [PRODUCT_W-1:0] out_data_q, out_data_d;
  logic [CFG_W-1:0]     cfg_sat;
  brm_ctrl_t            ctrl;
  logic [MAX_WIDTH-1:0] a_vec;
  logic [MAX_WIDTH-1:0] q_vec;
  logic [PRODUCT_W-1:0] prod;
  logic                 s_accept;
  logic                 done;
  logic                 out_free;

  assign cfg_ready_o   = 1'b1;
  assign done          = (state_q == ST_RUN) && (cnt_q == width_q);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) || (done && out_free);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    priority if (cfg_data_i == '0) begin
      cfg_sat = CFG_W'(1);
    end else if (cfg_data_i > CFG_W'(MAX_WIDTH)) begin
      cfg_sat = CFG_W'(MAX_WIDTH);
    end else begin
      cfg_sat = cfg_data_i;
    end
    width_d = (cfg_valid_i && cfg_ready_o) ? WW'(cfg_sat) : width_q;
  end

  // Booth pair: 10 subtracts, 01 adds
  always_comb begin
    ctrl.load   = s_accept;
    ctrl.step   = (state_q == ST_RUN) && !done;
    ctrl.add_en = ctrl.step && (q_vec[0] != q1_q);
    ctrl.sub    = q_vec[0];
  end

  assign prod = (PRODUCT_W'(a_vec) << width_q) | PRODUCT_W'(q_vec);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    q1_d        = q1_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (done && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = prod;
      state_d     = ST_IDLE;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (s_accept) begin
      state_d = ST_RUN;
      cnt_d   = '0;
      q1_d    = 1'b0;
    end else if (ctrl.step) begin
      cnt_d = cnt_q + WW'(1);
      q1_d  = q_vec[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WW'(MAX_WIDTH);
      cnt_q       <= '0;
      q1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      cnt_q       <= cnt_d;
      q1_q        <= q1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  brm_array #(
    .MAX_WIDTH (MAX_WIDTH),
    .WW        (WW)
  ) u_array (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .width_i  (width_q),
    .mcand_i  (s_axis_tdata[MAX_WIDTH-1:0]),
    .mplier_i (s_axis_tdata[OPERAND_W+MAX_WIDTH-1:OPERAND_W]),
    .a_o      (a_vec),
    .q_o      (q_vec)
  );

endmodule

@@ sv/brm_checker.sv @@
// Port-level checks for the Booth multiplier, bound to the top level.
module brm_checker import brm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [PRODUCT_W-1:0]   m_axis_tdata
);

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // at least one Booth round follows every accepted word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before a round ran");

endmodule

bind booth_radix2_multiplier_core brm_checker u_brm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
